// ===== src/nbts_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nbts_pkg
// Shared types, codes and float helpers of the term scoring block.
// ---------------------------------------------------------------------------
package nbts_pkg;

    // Table geometry and field widths
    localparam int TABLE_DEPTH = 1024;
    localparam int COUNT_WIDTH = 16;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENTRY_W     = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W       = 26;
    localparam int ID_W        = 32;
    localparam int ROW_W       = ID_W + COUNT_WIDTH;

    // Request codes
    localparam logic [1:0] REQ_PROFILE = 2'd0;
    localparam logic [1:0] REQ_DOC     = 2'd1;
    localparam logic [1:0] REQ_FINISH  = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_LATE_PRF = 2'd2;

    // Single precision constants
    localparam logic [31:0] FP_ZERO = 32'h0000_0000;
    localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [31:0] FP_TWO  = 32'h4000_0000;
    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] FP_PINF = 32'h7F80_0000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] term_id;
        logic [15:0] term_count;
    } in_item_t;

    typedef struct packed {
        logic [31:0] score_bits;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CONV,
        ST_MUL,
        ST_RND,
        ST_DIV,
        ST_RESP
    } state_t;

    // Operand classes; operands here are never subnormal
    typedef enum logic [1:0] {
        FK_NORM,
        FK_ZERO,
        FK_INF,
        FK_NAN
    } fp_kind_t;

    function automatic fp_kind_t fp_class(input logic [31:0] x);
        fp_kind_t k;
        if (x[30:23] == 8'hFF) begin
            k = (x[22:0] != 23'd0) ? FK_NAN : FK_INF;
        end else if (x[30:23] == 8'h00) begin
            k = FK_ZERO;
        end else begin
            k = FK_NORM;
        end
        return k;
    endfunction

    // Unsigned integer to single, round to nearest even
    function automatic logic [31:0] u2f(input logic [SUM_W-1:0] v);
        int               p;
        logic [SUM_W-1:0] norm;
        logic [22:0]      mant;
        logic             rnd;
        logic [31:0]      r;
        p = 0;
        for (int i = 0; i < SUM_W; i++) begin
            if (v[i]) begin
                p = i;
            end
        end
        norm = v << (SUM_W - 1 - p);
        mant = norm[24:2];
        rnd  = norm[1] & (norm[0] | mant[0]);
        r    = {1'b0, 8'(127 + p), mant} + {31'd0, rnd};
        if (v == '0) begin
            r = FP_ZERO;
        end
        return r;
    endfunction

endpackage

// ===== src/nbts_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nbts_ram
// Simple dual port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module nbts_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 48,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/nbts_fmul.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nbts_fmul
// Two stage single precision multiplier for operands that are zero,
// normal, infinite or NaN. Product register, then round on the output.
// ---------------------------------------------------------------------------
module nbts_fmul
    import nbts_pkg::*;
(
    input  logic        aclk,
    input  logic        load,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    logic [47:0] prod_reg;
    logic [9:0]  esum_reg;
    fp_kind_t    kind_reg;

    fp_kind_t    ka;
    fp_kind_t    kb;
    fp_kind_t    kind_next;

    // Operand classes decide the special result
    always_comb begin
        ka = fp_class(a);
        kb = fp_class(b);
        if (ka == FK_NAN || kb == FK_NAN) begin
            kind_next = FK_NAN;
        end else if ((ka == FK_INF && kb == FK_ZERO) || (ka == FK_ZERO && kb == FK_INF)) begin
            kind_next = FK_NAN;
        end else if (ka == FK_INF || kb == FK_INF) begin
            kind_next = FK_INF;
        end else if (ka == FK_ZERO || kb == FK_ZERO) begin
            kind_next = FK_ZERO;
        end else begin
            kind_next = FK_NORM;
        end
    end

    // Mantissa product stage
    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= {1'b1, a[22:0]} * {1'b1, b[22:0]};
            esum_reg <= {2'b00, a[30:23]} + {2'b00, b[30:23]} - 10'd127;
            kind_reg <= kind_next;
        end
    end

    // Normalize and round
    logic [22:0] mant;
    logic        grd;
    logic        stk;
    logic [9:0]  ex;

    always_comb begin
        if (prod_reg[47]) begin
            mant = prod_reg[46:24];
            grd  = prod_reg[23];
            stk  = |prod_reg[22:0];
            ex   = esum_reg + 10'd1;
        end else begin
            mant = prod_reg[45:23];
            grd  = prod_reg[22];
            stk  = |prod_reg[21:0];
            ex   = esum_reg;
        end
        unique case (kind_reg)
            FK_NAN:  y = FP_QNAN;
            FK_INF:  y = FP_PINF;
            FK_ZERO: y = FP_ZERO;
            default: begin
                if (ex >= 10'd255) begin
                    y = FP_PINF;
                end else begin
                    y = {1'b0, ex[7:0], mant} + {31'd0, grd & (stk | mant[0])};
                end
            end
        endcase
    end

endmodule

// ===== src/nbts_fdiv.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nbts_fdiv
// Radix 2 restoring single precision divider, one quotient bit per cycle,
// with gradual underflow and round to nearest even.
// ---------------------------------------------------------------------------
module nbts_fdiv
    import nbts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] y
);

    localparam int QBITS = 27;

    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [4:0]        bit_cnt_reg;
    logic [25:0]       rem_reg;
    logic [QBITS-1:0]  quo_reg;
    logic [23:0]       mb_reg;
    logic signed [9:0] exp_reg;
    logic [31:0]       y_reg;

    fp_kind_t    ka;
    fp_kind_t    kb;
    logic        special;
    logic [31:0] special_y;
    logic [23:0] ma;
    logic [23:0] mb;
    logic        lt;

    // Special operands finish at once
    always_comb begin
        ka        = fp_class(a);
        kb        = fp_class(b);
        special   = 1'b1;
        special_y = FP_ZERO;
        if (ka == FK_NAN || kb == FK_NAN) begin
            special_y = FP_QNAN;
        end else if (kb == FK_ZERO) begin
            special_y = (ka == FK_ZERO) ? FP_QNAN : FP_PINF;
        end else if (ka == FK_INF) begin
            special_y = (kb == FK_INF) ? FP_QNAN : FP_PINF;
        end else if (kb == FK_INF || ka == FK_ZERO) begin
            special_y = FP_ZERO;
        end else begin
            special = 1'b0;
        end
        ma = {1'b1, a[22:0]};
        mb = {1'b1, b[22:0]};
        lt = (ma < mb);
    end

    // One restoring step
    logic        ge;
    logic [25:0] rem_sub;

    always_comb begin
        ge      = (rem_reg >= {2'b00, mb_reg});
        rem_sub = ge ? (rem_reg - {2'b00, mb_reg}) : rem_reg;
    end

    // Denormalize and round
    logic [QBITS-1:0] qs;
    logic             st;
    logic [7:0]       ef;
    logic [22:0]      mant;
    logic             rnd;
    logic [31:0]      round_y;
    int               sh;

    always_comb begin
        sh = 0;
        if (exp_reg >= 10'sd1) begin
            qs = quo_reg;
            st = 1'b0;
            ef = exp_reg[7:0];
        end else begin
            sh = 1 - int'(exp_reg);
            if (sh > QBITS) begin
                sh = QBITS;
            end
            qs = quo_reg >> sh;
            st = |(quo_reg & ((QBITS'(1) << sh) - QBITS'(1)));
            ef = 8'd0;
        end
        mant = qs[25:3];
        rnd  = qs[2] & (qs[1] | qs[0] | st | (rem_reg != 26'd0) | mant[0]);
        if (exp_reg >= 10'sd255) begin
            round_y = FP_PINF;
        end else begin
            round_y = {1'b0, ef, mant} + {31'd0, rnd};
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= !special;
                done_reg <= special;
            end else if (busy_reg) begin
                if (bit_cnt_reg == 5'(QBITS - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            y_reg       <= special_y;
            bit_cnt_reg <= 5'd0;
            mb_reg      <= mb;
            rem_reg     <= lt ? {1'b0, ma, 1'b0} : {2'b00, ma};
            quo_reg     <= '0;
            exp_reg     <= signed'({2'b00, a[30:23]}) - signed'({2'b00, b[30:23]})
                           + 10'sd127 - signed'({9'd0, lt});
        end else if (busy_reg) begin
            quo_reg     <= {quo_reg[QBITS-2:0], ge};
            rem_reg     <= {rem_sub[24:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg + 5'd1;
        end else if (fin_reg) begin
            y_reg <= round_y;
        end
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

// ===== src/naive_bayes_term_score.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// naive_bayes_term_score
// Scores a document against a loaded profile in single precision.
// ---------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   s_item  (in_item_t)
//  m_        out        m_valid / m_ready   m_item  (out_item_t)
//
//  One item is worked at a time; s_ready is high only while idle.
//  Profile item: a table write. Document item: table search, conversion,
//  then count repetitions; the table search reads one entry per cycle from
//  the table RAM and each repetition takes the two stage multiplier pair.
//  Finish item: after a document, runs the bit serial divider.
//  Reset (synchronous, aresetn low) empties the table; no clearing pass.
//  A held result stalls the block in its response state until m_ready.
// ---------------------------------------------------------------------------
module naive_bayes_term_score
    import nbts_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    state_t               state_reg, state_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic [ENTRY_W-1:0]   entries_reg, entries_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [31:0]          dvd_reg, dvd_next;
    logic [31:0]          dvs_reg, dvs_next;
    logic                 started_reg, started_next;
    logic [ENTRY_W-1:0]   issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [ENTRY_W-1:0]   cmp_reg, cmp_next;
    logic                 found_reg, found_next;
    logic [COUNT_WIDTH-1:0] hit_cnt_reg, hit_cnt_next;
    logic [31:0]          num_reg, num_next;
    logic [31:0]          den_reg, den_next;
    logic [COUNT_WIDTH-1:0] rep_reg, rep_next;
    out_item_t            res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_item_reg, m_item_next;

    logic                 accept;
    logic [COUNT_WIDTH-1:0] in_cnt;

    // Table RAM ports
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ROW_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [ROW_W-1:0]     ram_rdata;

    logic [ID_W-1:0]      rd_id;
    logic [COUNT_WIDTH-1:0] rd_cnt;
    logic                 hit;
    logic                 last;

    logic                 mul_load;
    logic [31:0]          dvd_prod;
    logic [31:0]          dvs_prod;
    logic                 div_start;
    logic                 div_done;
    logic [31:0]          div_y;

    nbts_ram #(
        .DEPTH  (TABLE_DEPTH),
        .WIDTH  (ROW_W),
        .ADDR_W (ADDR_W)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (issue_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    nbts_fmul u_mul_dvd (
        .aclk (aclk),
        .load (mul_load),
        .a    (dvd_reg),
        .b    (num_reg),
        .y    (dvd_prod)
    );

    nbts_fmul u_mul_dvs (
        .aclk (aclk),
        .load (mul_load),
        .a    (dvs_reg),
        .b    (den_reg),
        .y    (dvs_prod)
    );

    nbts_fdiv u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (dvd_reg),
        .b       (dvs_reg),
        .done    (div_done),
        .y       (div_y)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_cnt   = s_item.term_count[COUNT_WIDTH-1:0];
    assign rd_id    = ram_rdata[ROW_W-1 -: ID_W];
    assign rd_cnt   = ram_rdata[COUNT_WIDTH-1:0];
    assign hit      = pend_reg && (rd_id == id_reg);
    assign last     = pend_reg && (cmp_reg == entries_reg - ENTRY_W'(1));
    assign mul_load = (state_reg == ST_MUL);

    // Next state and datapath control
    always_comb begin
        state_next   = state_reg;
        id_next      = id_reg;
        cnt_next     = cnt_reg;
        entries_next = entries_reg;
        sum_next     = sum_reg;
        dvd_next     = dvd_reg;
        dvs_next     = dvs_reg;
        started_next = started_reg;
        issue_next   = issue_reg;
        pend_next    = pend_reg;
        cmp_next     = cmp_reg;
        found_next   = found_reg;
        hit_cnt_next = hit_cnt_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rep_next     = rep_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        ram_we       = 1'b0;
        ram_waddr    = entries_reg[ADDR_W-1:0];
        ram_wdata    = {s_item.term_id, in_cnt};
        ram_re       = 1'b0;
        div_start    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next.score_bits = FP_ZERO;
                    res_next.status     = STAT_OK;
                    state_next          = ST_RESP;
                    unique case (s_item.req_type)
                        REQ_PROFILE: begin
                            if (started_reg) begin
                                res_next.status = STAT_LATE_PRF;
                            end else if (entries_reg >= ENTRY_W'(TABLE_DEPTH)) begin
                                res_next.status = STAT_FULL;
                            end else begin
                                ram_we       = 1'b1;
                                entries_next = entries_reg + ENTRY_W'(1);
                                sum_next     = sum_reg + SUM_W'(in_cnt);
                            end
                        end
                        REQ_DOC: begin
                            started_next = 1'b1;
                            id_next      = s_item.term_id;
                            cnt_next     = in_cnt;
                            found_next   = 1'b0;
                            issue_next   = '0;
                            pend_next    = 1'b0;
                            state_next   = (entries_reg == '0) ? ST_CONV : ST_SEARCH;
                        end
                        REQ_FINISH: begin
                            if (started_reg) begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                            entries_next = '0;
                            sum_next     = '0;
                            dvd_next     = FP_ONE;
                            dvs_next     = FP_ONE;
                            started_next = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    found_next   = 1'b1;
                    hit_cnt_next = rd_cnt;
                    pend_next    = 1'b0;
                    state_next   = ST_CONV;
                end else if (last) begin
                    pend_next  = 1'b0;
                    state_next = ST_CONV;
                end else begin
                    ram_re    = (issue_reg < entries_reg);
                    pend_next = ram_re;
                    cmp_next  = issue_reg;
                    if (ram_re) begin
                        issue_next = issue_reg + ENTRY_W'(1);
                    end
                end
            end
            ST_CONV: begin
                num_next   = found_reg ? u2f(SUM_W'(hit_cnt_reg)) : FP_ONE;
                den_next   = found_reg ? u2f(sum_reg) : FP_TWO;
                rep_next   = cnt_reg;
                state_next = (cnt_reg == '0) ? ST_RESP : ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_RND;
            end
            ST_RND: begin
                dvd_next   = dvd_prod;
                dvs_next   = dvs_prod;
                rep_next   = rep_reg - COUNT_WIDTH'(1);
                state_next = (rep_reg == COUNT_WIDTH'(1)) ? ST_RESP : ST_MUL;
            end
            ST_DIV: begin
                if (div_done) begin
                    res_next.score_bits = div_y;
                    state_next          = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_item_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            entries_reg <= '0;
            sum_reg     <= '0;
            dvd_reg     <= FP_ONE;
            dvs_reg     <= FP_ONE;
            started_reg <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            entries_reg <= entries_next;
            sum_reg     <= sum_next;
            dvd_reg     <= dvd_next;
            dvs_reg     <= dvs_next;
            started_reg <= started_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        id_reg      <= id_next;
        cnt_reg     <= cnt_next;
        issue_reg   <= issue_next;
        cmp_reg     <= cmp_next;
        found_reg   <= found_next;
        hit_cnt_reg <= hit_cnt_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        rep_reg     <= rep_next;
        res_reg     <= res_next;
        m_item_reg  <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Checks
    a_entries_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entries_reg <= ENTRY_W'(TABLE_DEPTH))
        else $error("profile entry count beyond table depth");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (issue_reg <= entries_reg))
        else $error("search read past last profile entry");

    a_rep_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (rep_reg != '0))
        else $error("multiply issued with no repetitions left");

    a_finish_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.req_type == REQ_FINISH)
        |=> (entries_reg == '0 && !started_reg && dvd_reg == FP_ONE))
        else $error("finish item did not clear the profile");

endmodule
